// ===== rtl/core/nlr_pkg.sv =====
package nlr_pkg;

    // Recognizer states; codes 8 and 15 are unused and behave as the dead state.
    typedef enum logic [3:0] {
        ST_START  = 4'd0,
        ST_SIGN   = 4'd1,
        ST_INT    = 4'd2,
        ST_DOT    = 4'd3,
        ST_ZERO   = 4'd4,
        ST_HEXPFX = 4'd5,
        ST_L1     = 4'd6,
        ST_L2     = 4'd7,
        ST_FRAC   = 4'd9,
        ST_EXP    = 4'd10,
        ST_EXPDIG = 4'd11,
        ST_EXPSGN = 4'd12,
        ST_DEAD   = 4'd13,
        ST_HEXDIG = 4'd14
    } scan_state_t;

    // Status of one transition, handed from the transition logic to the top level.
    typedef struct packed {
        logic dead;
        logic final_ok;
    } step_flags_t;

    localparam int CH_W = 8;

    localparam logic [CH_W-1:0] CH_X_LO  = 8'h78;
    localparam logic [CH_W-1:0] CH_X_UP  = 8'h58;
    localparam logic [CH_W-1:0] CH_L_LO  = 8'h6C;
    localparam logic [CH_W-1:0] CH_L_UP  = 8'h4C;
    localparam logic [CH_W-1:0] CH_E_LO  = 8'h65;
    localparam logic [CH_W-1:0] CH_E_UP  = 8'h45;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_A_LO  = 8'h61;
    localparam logic [CH_W-1:0] CH_F_LO  = 8'h66;
    localparam logic [CH_W-1:0] CH_A_UP  = 8'h41;
    localparam logic [CH_W-1:0] CH_F_UP  = 8'h46;

    // Output word layout (tdata bits).
    localparam int OUT_W      = 8;
    localparam int OUT_DEAD   = 0;
    localparam int OUT_ACCEPT = 1;

endpackage

// ===== rtl/core/numeric_literal_recognizer.sv =====
// Channel   | Dir | tdata (lowest bit up)             | tlast    | tuser
// s_axis    | in  | ch[7:0]                           | last     | -
// m_axis    | out | dead, accept, 6'b0 padding        | done_res | -
//
// One character word per cycle, sustained while m_axis_tready stays high; each
// character passes the input register, then the result register.
// The scan state loop is one combinational table transition, closed through scan_state_reg.
// rst_n (async, active low) empties both registers and returns to the start state.
// A stalled output holds its word; the input register keeps filling behind it
// until both registers are full, then s_axis_tready drops.
module numeric_literal_recognizer
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    input  logic       s_axis_tlast,   // last

    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [0] dead, [1] accept, [7:2] zero
    output logic       m_axis_tlast    // done_res
);

    // Input register
    logic                 in_valid_reg;
    logic [7:0]           in_ch_reg;
    logic                 in_last_reg;

    // Result register
    logic                 out_valid_reg;
    logic                 out_dead_reg;
    logic                 out_accept_reg;
    logic                 out_last_reg;

    // Recognizer state
    nlr_pkg::scan_state_t scan_state_reg;
    nlr_pkg::scan_state_t scan_state_next;

    nlr_pkg::scan_state_t step_state;
    nlr_pkg::step_flags_t step_flags;

    logic                 out_free;
    logic                 advance;
    logic                 in_take;

    nlr_next u_next
    (
        .cur   (scan_state_reg),
        .ch    (in_ch_reg),
        .nxt   (step_state),
        .flags (step_flags)
    );

    // The result register frees up when empty or being drained this cycle.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Drop back to start after the last character of a string.
    always_comb
    begin
        scan_state_next = scan_state_reg;
        if (advance)
        begin
            scan_state_next = in_last_reg ? nlr_pkg::ST_START : step_state;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_state_reg <= nlr_pkg::ST_START;
        end
        else
        begin
            scan_state_reg <= scan_state_next;

            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on handshake, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_ch_reg   <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_dead_reg   <= step_flags.dead;
            out_accept_reg <= in_last_reg && step_flags.final_ok;
            out_last_reg   <= in_last_reg;
        end
    end

    always_comb
    begin
        m_axis_tdata                      = '0;
        m_axis_tdata[nlr_pkg::OUT_DEAD]   = out_dead_reg;
        m_axis_tdata[nlr_pkg::OUT_ACCEPT] = out_accept_reg;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    // A string's last character always returns the recognizer to start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg) |=> (scan_state_reg == nlr_pkg::ST_START))
        else $error("scan state not cleared after last character");

    // A legal string is never dead.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_dead_reg && out_accept_reg))
        else $error("result both dead and accepted");

    // Accept is only reported on a last character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_accept_reg) |-> out_last_reg)
        else $error("accept on a non-last character");

    // A word moves into a full result register only when it drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && out_valid_reg) |-> m_axis_tready)
        else $error("result register overwritten while stalled");
`endif

endmodule

// ===== rtl/core/nlr_next.sv =====
module nlr_next
(
    input  nlr_pkg::scan_state_t   cur,
    input  logic [7:0]             ch,
    output nlr_pkg::scan_state_t   nxt,
    output nlr_pkg::step_flags_t   flags
);

    logic is_dec;
    logic is_hex;
    logic is_ell;
    logic is_e;
    logic is_sign;
    logic is_x;
    logic is_zero;
    logic is_dot;

    // Classify the character.
    always_comb
    begin
        is_dec  = (ch >= nlr_pkg::CH_ZERO) && (ch <= nlr_pkg::CH_NINE);
        is_hex  = is_dec
                  || ((ch >= nlr_pkg::CH_A_LO) && (ch <= nlr_pkg::CH_F_LO))
                  || ((ch >= nlr_pkg::CH_A_UP) && (ch <= nlr_pkg::CH_F_UP));
        is_ell  = (ch == nlr_pkg::CH_L_LO) || (ch == nlr_pkg::CH_L_UP);
        is_e    = (ch == nlr_pkg::CH_E_LO) || (ch == nlr_pkg::CH_E_UP);
        is_sign = (ch == nlr_pkg::CH_PLUS) || (ch == nlr_pkg::CH_MINUS);
        is_x    = (ch == nlr_pkg::CH_X_LO) || (ch == nlr_pkg::CH_X_UP);
        is_zero = (ch == nlr_pkg::CH_ZERO);
        is_dot  = (ch == nlr_pkg::CH_DOT);
    end

    always_comb
    begin
        nxt = nlr_pkg::ST_DEAD;
        unique case (cur)
            nlr_pkg::ST_START:
            begin
                if (is_sign)      nxt = nlr_pkg::ST_SIGN;
                else if (is_dot)  nxt = nlr_pkg::ST_DOT;
                else if (is_zero) nxt = nlr_pkg::ST_ZERO;
                else if (is_dec)  nxt = nlr_pkg::ST_INT;
            end
            nlr_pkg::ST_SIGN:
            begin
                if (is_zero)      nxt = nlr_pkg::ST_ZERO;
                else if (is_dec)  nxt = nlr_pkg::ST_INT;
                else if (is_dot)  nxt = nlr_pkg::ST_DOT;
            end
            nlr_pkg::ST_INT:
            begin
                if (is_dec)       nxt = nlr_pkg::ST_INT;
                else if (is_ell)  nxt = nlr_pkg::ST_L1;
                else if (is_dot)  nxt = nlr_pkg::ST_FRAC;
                else if (is_e)    nxt = nlr_pkg::ST_EXP;
            end
            nlr_pkg::ST_DOT:
            begin
                if (is_dec)       nxt = nlr_pkg::ST_FRAC;
            end
            nlr_pkg::ST_ZERO:
            begin
                if (is_x)         nxt = nlr_pkg::ST_HEXPFX;
                else if (is_dec)  nxt = nlr_pkg::ST_INT;
                else if (is_ell)  nxt = nlr_pkg::ST_L1;
                else if (is_dot)  nxt = nlr_pkg::ST_FRAC;
                else if (is_e)    nxt = nlr_pkg::ST_EXP;
            end
            nlr_pkg::ST_HEXPFX:
            begin
                if (is_hex)       nxt = nlr_pkg::ST_HEXDIG;
            end
            nlr_pkg::ST_HEXDIG:
            begin
                // an l/L suffix wins over the hex digit test
                if (is_ell)       nxt = nlr_pkg::ST_L1;
                else if (is_hex)  nxt = nlr_pkg::ST_HEXDIG;
            end
            nlr_pkg::ST_L1:
            begin
                if (is_ell)       nxt = nlr_pkg::ST_L2;
            end
            nlr_pkg::ST_FRAC:
            begin
                if (is_dec)       nxt = nlr_pkg::ST_FRAC;
                else if (is_e)    nxt = nlr_pkg::ST_EXP;
            end
            nlr_pkg::ST_EXP:
            begin
                if (is_sign)      nxt = nlr_pkg::ST_EXPSGN;
                else if (is_dec)  nxt = nlr_pkg::ST_EXPDIG;
            end
            nlr_pkg::ST_EXPSGN,
            nlr_pkg::ST_EXPDIG:
            begin
                if (is_dec)       nxt = nlr_pkg::ST_EXPDIG;
            end
            default:
            begin
                nxt = nlr_pkg::ST_DEAD;
            end
        endcase
    end

    always_comb
    begin
        flags.dead     = (nxt == nlr_pkg::ST_DEAD);
        flags.final_ok = (nxt == nlr_pkg::ST_INT)    || (nxt == nlr_pkg::ST_ZERO)
                      || (nxt == nlr_pkg::ST_L1)     || (nxt == nlr_pkg::ST_L2)
                      || (nxt == nlr_pkg::ST_FRAC)   || (nxt == nlr_pkg::ST_EXPDIG)
                      || (nxt == nlr_pkg::ST_HEXDIG);
    end

endmodule
